/* design/a2ab_pkg.sv */
// ----------------------------------------------------------------------------
// a2ab_pkg
// Shared types and constants for the address block generator.
// ----------------------------------------------------------------------------
package a2ab_pkg;

    localparam int BLOCK_WORDS = 128;
    localparam int COLS = BLOCK_WORDS / 4;
    localparam int COL_W = $clog2(COLS);
    localparam int INPUT_WORDS = 7;
    localparam int QUEUE_DEPTH_DEFAULT = 2;
    localparam int MIX_STAGES = 4;

    typedef struct packed {
        logic [31:0] pass_index;
        logic [31:0] lane_index;
        logic [31:0] slice_index;
        logic [31:0] total_blocks;
        logic [31:0] total_passes;
        logic [31:0] variant_type;
        logic [31:0] block_counter;
    } item_t;

    typedef struct packed {
        logic [4:0]  result_index;
        logic [63:0] word_row0;
        logic [63:0] word_row1;
        logic [63:0] word_row2;
        logic [63:0] word_row3;
        logic        last_result;
    } result_t;

    // One column: row r holds block word r*COLS + t.
    typedef logic [3:0][63:0] col_t;
    typedef col_t [COLS-1:0] block_t;

    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] index;
        col_t             column;
    } mix_beat_t;

    typedef enum logic [2:0] {
        OP_SWAP,
        OP_MIX,
        OP_NEAR13,
        OP_NEAR31,
        OP_FAR13,
        OP_FAR31
    } op_t;

endpackage

/* design/a2ab_queue.sv */
// ----------------------------------------------------------------------------
// a2ab_queue
// Front part: takes input transfers and holds them until the back is free.
// ----------------------------------------------------------------------------
module a2ab_queue #(
    parameter int DEPTH = a2ab_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  a2ab_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output a2ab_pkg::item_t head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    a2ab_pkg::item_t store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push) else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty) else $error("queue read while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH)) else $error("queue count out of range");

endmodule

/* design/a2ab_mix.sv */
// ----------------------------------------------------------------------------
// a2ab_mix
// Four-stage pipelined multiply-add quarter round over one column.
// ----------------------------------------------------------------------------
module a2ab_mix (
    input  logic                clk,
    input  logic                rst_n,
    input  a2ab_pkg::mix_beat_t in_beat,
    output a2ab_pkg::mix_beat_t out_beat
);

    a2ab_pkg::mix_beat_t stage_reg  [a2ab_pkg::MIX_STAGES];
    a2ab_pkg::mix_beat_t stage_next [a2ab_pkg::MIX_STAGES];

    function automatic logic [63:0] blamka(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] p;
        p = {32'b0, x[31:0]} * {32'b0, y[31:0]};
        return x + y + {p[62:0], 1'b0};
    endfunction

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    // Stage k: a/c update and d/b update, as in the column mix.
    always_comb
    begin
        a2ab_pkg::mix_beat_t src;
        for (int k = 0; k < a2ab_pkg::MIX_STAGES; k++)
        begin
            src = (k == 0) ? in_beat : stage_reg[(k == 0) ? 0 : k - 1];
            stage_next[k] = src;
            unique case (k)
                0:
                begin
                    stage_next[k].column[0] = blamka(src.column[0], src.column[1]);
                    stage_next[k].column[3] = rotr(src.column[3] ^ stage_next[k].column[0], 32);
                end
                1:
                begin
                    stage_next[k].column[2] = blamka(src.column[2], src.column[3]);
                    stage_next[k].column[1] = rotr(src.column[1] ^ stage_next[k].column[2], 24);
                end
                2:
                begin
                    stage_next[k].column[0] = blamka(src.column[0], src.column[1]);
                    stage_next[k].column[3] = rotr(src.column[3] ^ stage_next[k].column[0], 16);
                end
                default:
                begin
                    stage_next[k].column[2] = blamka(src.column[2], src.column[3]);
                    stage_next[k].column[1] = rotr(src.column[1] ^ stage_next[k].column[2], 63);
                end
            endcase
        end
    end

    // Only the valid flags are cleared by reset; data simply follows them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < a2ab_pkg::MIX_STAGES; k++)
            begin
                stage_reg[k].valid <= 1'b0;
            end
        end
        else
        begin
            for (int k = 0; k < a2ab_pkg::MIX_STAGES; k++)
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign out_beat = stage_reg[a2ab_pkg::MIX_STAGES - 1];

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat.valid |-> ##4 out_beat.valid) else $error("mix beat lost");
    a_index_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat.valid |-> ##4 (out_beat.index == $past(in_beat.index, 4)))
        else $error("mix index changed in flight");

endmodule

/* design/a2ab_engine.sv */
// ----------------------------------------------------------------------------
// a2ab_engine
// Back part: holds the block, sequences the permutation and emits columns.
// ----------------------------------------------------------------------------
module a2ab_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_ready,
    input  a2ab_pkg::item_t   item,
    output logic              item_take,
    output logic              result_valid,
    output a2ab_pkg::result_t result
);

    localparam int COLS  = a2ab_pkg::COLS;
    localparam int COL_W = a2ab_pkg::COL_W;
    localparam int OPS   = 10;
    localparam int OP_W  = $clog2(OPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_FOLD,
        ST_OUT
    } state_t;

    state_t              state_reg;
    logic [OP_W-1:0]     op_idx_reg;
    logic                pass_reg;
    logic [COL_W:0]      iss_cnt_reg;
    logic [COL_W-1:0]    wr_cnt_reg;
    logic [COL_W-1:0]    out_cnt_reg;
    a2ab_pkg::block_t    block_reg;
    a2ab_pkg::block_t    saved_reg;
    a2ab_pkg::item_t     item_reg;
    logic                result_valid_reg;
    a2ab_pkg::result_t   result_reg;

    a2ab_pkg::op_t       cur_op;
    a2ab_pkg::block_t    shuf_block;
    a2ab_pkg::block_t    fold_block;
    a2ab_pkg::block_t    load_block;
    a2ab_pkg::mix_beat_t mix_in;
    a2ab_pkg::mix_beat_t mix_out;

    function automatic a2ab_pkg::op_t op_at(input logic [OP_W-1:0] idx);
        a2ab_pkg::op_t op;
        unique case (idx)
            OP_W'(0): op = a2ab_pkg::OP_SWAP;
            OP_W'(1): op = a2ab_pkg::OP_MIX;
            OP_W'(2): op = a2ab_pkg::OP_NEAR13;
            OP_W'(3): op = a2ab_pkg::OP_MIX;
            OP_W'(4): op = a2ab_pkg::OP_NEAR31;
            OP_W'(5): op = a2ab_pkg::OP_SWAP;
            OP_W'(6): op = a2ab_pkg::OP_MIX;
            OP_W'(7): op = a2ab_pkg::OP_FAR13;
            OP_W'(8): op = a2ab_pkg::OP_MIX;
            default:  op = a2ab_pkg::OP_FAR31;
        endcase
        return op;
    endfunction

    function automatic logic [63:0] pick_a(input a2ab_pkg::block_t b, input logic [COL_W-1:0] s);
        return s[3] ? (s[2] ? b[s][2] : b[s][3]) : (s[2] ? b[s][0] : b[s][1]);
    endfunction

    function automatic logic [63:0] pick_b(input a2ab_pkg::block_t b, input logic [COL_W-1:0] s);
        return s[3] ? (s[2] ? b[s][1] : b[s][0]) : (s[2] ? b[s][3] : b[s][2]);
    endfunction

    function automatic logic [63:0] pick_c(input a2ab_pkg::block_t b, input logic [COL_W-1:0] s);
        return s[3] ? (s[2] ? b[s][0] : b[s][1]) : (s[2] ? b[s][2] : b[s][3]);
    endfunction

    function automatic a2ab_pkg::block_t swap_quads(input a2ab_pkg::block_t b);
        a2ab_pkg::block_t r;
        logic [COL_W-1:0] t;
        logic [63:0] y1;
        logic [63:0] y2;
        logic [63:0] y3;
        for (int i = 0; i < COLS; i++)
        begin
            t  = COL_W'(i);
            y1 = pick_a(b, t ^ COL_W'(4));
            y2 = pick_b(b, t ^ COL_W'(8));
            y3 = pick_c(b, t ^ COL_W'(12));
            r[i][0] = t[3] ? (t[2] ? y3 : y2) : (t[2] ? y1 : b[i][0]);
            r[i][1] = t[3] ? (t[2] ? y2 : y3) : (t[2] ? b[i][1] : y1);
            r[i][2] = t[3] ? (t[2] ? y1 : b[i][2]) : (t[2] ? y3 : y2);
            r[i][3] = t[3] ? (t[2] ? b[i][3] : y1) : (t[2] ? y2 : y3);
        end
        return r;
    endfunction

    function automatic a2ab_pkg::block_t rotate_near(input a2ab_pkg::block_t b,
                                                     input logic [1:0] kb,
                                                     input logic [1:0] kd);
        a2ab_pkg::block_t r;
        logic [COL_W-1:0] t;
        logic [COL_W-1:0] sb;
        logic [COL_W-1:0] sd;
        for (int i = 0; i < COLS; i++)
        begin
            t  = COL_W'(i);
            sb = {t[COL_W-1:2], t[1:0] + kb};
            sd = {t[COL_W-1:2], t[1:0] + kd};
            r[i][0] = b[i][0];
            r[i][1] = b[sb][1];
            r[i][2] = b[t ^ COL_W'(2)][2];
            r[i][3] = b[sd][3];
        end
        return r;
    endfunction

    function automatic a2ab_pkg::block_t rotate_far(input a2ab_pkg::block_t b,
                                                    input logic [1:0] kb,
                                                    input logic [1:0] kd);
        a2ab_pkg::block_t r;
        logic [COL_W-1:0] t;
        logic [1:0] lo;
        logic [1:0] lb;
        logic [1:0] ld;
        for (int i = 0; i < COLS; i++)
        begin
            t  = COL_W'(i);
            lo = {t[4], t[0]};
            lb = lo + kb;
            ld = lo + kd;
            r[i][0] = b[i][0];
            r[i][1] = b[{lb[1], t[3:1], lb[0]}][1];
            r[i][2] = b[t ^ COL_W'(16)][2];
            r[i][3] = b[{ld[1], t[3:1], ld[0]}][3];
        end
        return r;
    endfunction

    function automatic logic [63:0] item_word(input a2ab_pkg::item_t it, input int w);
        logic [31:0] v;
        unique case (w)
            0:       v = it.pass_index;
            1:       v = it.lane_index;
            2:       v = it.slice_index;
            3:       v = it.total_blocks;
            4:       v = it.total_passes;
            5:       v = it.variant_type;
            default: v = it.block_counter;
        endcase
        return {32'b0, v};
    endfunction

    assign cur_op = op_at(op_idx_reg);

    always_comb
    begin
        unique case (cur_op)
            a2ab_pkg::OP_SWAP:   shuf_block = swap_quads(block_reg);
            a2ab_pkg::OP_NEAR13: shuf_block = rotate_near(block_reg, 2'd1, 2'd3);
            a2ab_pkg::OP_NEAR31: shuf_block = rotate_near(block_reg, 2'd3, 2'd1);
            a2ab_pkg::OP_FAR13:  shuf_block = rotate_far(block_reg, 2'd1, 2'd3);
            a2ab_pkg::OP_FAR31:  shuf_block = rotate_far(block_reg, 2'd3, 2'd1);
            default:             shuf_block = block_reg;
        endcase
    end

    always_comb
    begin
        fold_block = block_reg;
        load_block = '0;
        for (int w = 0; w < a2ab_pkg::INPUT_WORDS; w++)
        begin
            fold_block[w][0] = block_reg[w][0] ^ item_word(item_reg, w);
            load_block[w][0] = item_word(item, w);
        end
    end

    assign item_take = (state_reg == ST_IDLE) && item_ready;

    always_comb
    begin
        mix_in.valid  = (state_reg == ST_RUN) && (cur_op == a2ab_pkg::OP_MIX)
                        && !iss_cnt_reg[COL_W];
        mix_in.index  = iss_cnt_reg[COL_W-1:0];
        mix_in.column = block_reg[iss_cnt_reg[COL_W-1:0]];
    end

    a2ab_mix u_mix (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_beat  (mix_in),
        .out_beat (mix_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            op_idx_reg       <= '0;
            pass_reg         <= 1'b0;
            iss_cnt_reg      <= '0;
            wr_cnt_reg       <= '0;
            out_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_ready)
                    begin
                        block_reg   <= load_block;
                        item_reg    <= item;
                        pass_reg    <= 1'b0;
                        op_idx_reg  <= '0;
                        iss_cnt_reg <= '0;
                        wr_cnt_reg  <= '0;
                        state_reg   <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (cur_op == a2ab_pkg::OP_MIX)
                    begin
                        if (mix_in.valid)
                        begin
                            iss_cnt_reg <= iss_cnt_reg + 1'b1;
                        end
                        if (mix_out.valid)
                        begin
                            block_reg[mix_out.index] <= mix_out.column;
                            wr_cnt_reg <= wr_cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        block_reg <= shuf_block;
                    end
                    if ((cur_op != a2ab_pkg::OP_MIX)
                        || (mix_out.valid && wr_cnt_reg == COL_W'(COLS - 1)))
                    begin
                        iss_cnt_reg <= '0;
                        wr_cnt_reg  <= '0;
                        if (op_idx_reg == OP_W'(OPS - 1))
                        begin
                            op_idx_reg  <= '0;
                            out_cnt_reg <= '0;
                            state_reg   <= pass_reg ? ST_OUT : ST_FOLD;
                        end
                        else
                        begin
                            op_idx_reg <= op_idx_reg + 1'b1;
                        end
                    end
                end
                ST_FOLD:
                begin
                    block_reg <= fold_block;
                    saved_reg <= fold_block;
                    pass_reg  <= 1'b1;
                    state_reg <= ST_RUN;
                end
                default:
                begin
                    result_valid_reg         <= 1'b1;
                    result_reg.result_index  <= out_cnt_reg;
                    result_reg.word_row0     <= block_reg[out_cnt_reg][0] ^ saved_reg[out_cnt_reg][0];
                    result_reg.word_row1     <= block_reg[out_cnt_reg][1] ^ saved_reg[out_cnt_reg][1];
                    result_reg.word_row2     <= block_reg[out_cnt_reg][2] ^ saved_reg[out_cnt_reg][2];
                    result_reg.word_row3     <= block_reg[out_cnt_reg][3] ^ saved_reg[out_cnt_reg][3];
                    result_reg.last_result   <= (out_cnt_reg == COL_W'(COLS - 1));
                    out_cnt_reg              <= out_cnt_reg + 1'b1;
                    if (out_cnt_reg == COL_W'(COLS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last_result) |-> (result.result_index == COL_W'(COLS - 1)))
        else $error("last flag on wrong column");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |=> (state_reg == ST_RUN)) else $error("item taken but not started");
    a_mix_only_in_mix: assert property (@(posedge clk) disable iff (!rst_n)
        mix_out.valid |-> (state_reg == ST_RUN && cur_op == a2ab_pkg::OP_MIX))
        else $error("mix write-back outside a mix pass");

endmodule

/* design/argon2_address_block_generator.sv */
// ----------------------------------------------------------------------------
// argon2_address_block_generator
// Computes the data-independent address block G(0, G(0, input)).
// ----------------------------------------------------------------------------
//
//   channel   signals               direction  transfer taken when
//   input     start, busy, item     in         start high and busy low
//   result    result_valid, result  out        every cycle result_valid is high
//
// Each input transfer yields 32 result transfers, one per block column, in
// column order, the last flagged by last_result. An item holds the back part
// until its last result is out: a load, two permutations (each four mix
// passes through the shared four-stage quarter-round pipeline, each pass
// issuing 32 columns and then draining, plus six whole-block shuffles), a
// fold between the permutations and 32 output beats; the back part takes
// no new item before it is done. busy is high only when the input queue is
// full, so further items are taken while one is being worked on. Reset clears
// the queue, the sequencer and the pipeline valid flags; the block contents are
// written in full by each item before they are read. The receiver cannot stall
// results.
//
module argon2_address_block_generator #(
    parameter int QUEUE_DEPTH = a2ab_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  a2ab_pkg::item_t   item,
    output logic              result_valid,
    output a2ab_pkg::result_t result
);

    logic            queue_full;
    logic            queue_not_empty;
    logic            queue_pop;
    logic            push;
    a2ab_pkg::item_t head_item;

    // An item is taken into the queue when start is high and there is room for it.
    assign busy = queue_full;
    assign push = start && !queue_full;

    a2ab_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (item),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .head_item (head_item)
    );

    // The engine pops one item when it is idle and runs it to completion.
    a2ab_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_ready   (queue_not_empty),
        .item         (head_item),
        .item_take    (queue_pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
